### design/sls_pkg.sv
// Package for the slew limited supply sequencer: widths, fixed-point constants,
// action and register codes, and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package sls_pkg;

    // Fixed-point and timestamp widths.
    localparam int FRAC_BITS = 24;
    localparam int TIME_BITS = 32;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int SETTLE_W  = 16;
    localparam int SCALE_W   = 18;
    localparam int SCALE_SH  = 16;

    // Fraction constants derived from the fraction width.
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic [FRAC_W-1:0] ONE_FRAC   = FRAC_W'(ONE_L);
    localparam logic [FRAC_W-1:0] MIN_ARMED  = FRAC_W'((ONE_L + 500) / 1000);
    localparam logic [FRAC_W-1:0] OFF_THRESH = FRAC_W'(ONE_L / 100);
    localparam logic [FRAC_W:0]   STEP_MAX   = (FRAC_W + 1)'(ONE_L * 2);
    localparam logic [TIME_BITS-1:0] OFF_TIMEOUT_MS = TIME_BITS'(3000);

    // Action codes carried on the input sideband.
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_ARM    = 2'd1;
    localparam logic [1:0] ACT_DISARM = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIA_LINK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_SCALE   = 3'd4;

    // Stream widths.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;

    typedef struct packed {
        logic                via_link;
        logic [FRAC_W-1:0]   normal_rate;
        logic [FRAC_W-1:0]   shutdown_rate;
        logic [SETTLE_W-1:0] settle_ms;
        logic [SCALE_W-1:0]  level_scale;
    } t_cfg;

    // Result of the sequencing step, before the link level is scaled.
    typedef struct packed {
        logic [FRAC_W-1:0] applied;
        logic              remote;
        logic              enable;
        logic              telemetry_ok;
        logic              armed;
    } t_step;

endpackage

### design/sls_cfg.sv
// Configuration register file for the slew limited supply sequencer.
// Depends on sls_pkg.
`timescale 1ns / 1ps

module sls_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sls_pkg::FRAC_W-1:0]   i_cfg_data,
    output sls_pkg::t_cfg                o_cfg
);
    import sls_pkg::*;

    t_cfg r_cfg;

    // Writes are always taken; an unknown index changes nothing.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.via_link      <= 1'b0;
            r_cfg.normal_rate   <= FRAC_W'(1678);
            r_cfg.shutdown_rate <= FRAC_W'(3355);
            r_cfg.settle_ms     <= SETTLE_W'(50);
            r_cfg.level_scale   <= SCALE_W'(65536);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VIA_LINK:      r_cfg.via_link      <= i_cfg_data[0];
                CFG_NORMAL_RATE:   r_cfg.normal_rate   <= i_cfg_data;
                CFG_SHUTDOWN_RATE: r_cfg.shutdown_rate <= i_cfg_data;
                CFG_SETTLE_MS:     r_cfg.settle_ms     <= i_cfg_data[SETTLE_W-1:0];
                CFG_LEVEL_SCALE:   r_cfg.level_scale   <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

### design/sls_core.sv
// Input register, sequencer state and slew step for the supply sequencer.
// One word is processed per cycle unless the downstream stalls; the step result
// goes to a stage register. Depends on sls_pkg.
`timescale 1ns / 1ps

module sls_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sls_pkg::t_cfg                i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_action,
    input  logic [sls_pkg::TIME_BITS-1:0] i_now_ms,
    input  logic [sls_pkg::FRAC_W-1:0]   i_setpoint,
    input  logic                         i_telemetry_valid,
    input  logic                         i_supply_fault,
    output logic                         o_step_valid,
    input  logic                         i_step_ready,
    output sls_pkg::t_step               o_step
);
    import sls_pkg::*;

    localparam int DT_W   = (TIME_BITS > FRAC_W) ? TIME_BITS : FRAC_W + 1;
    localparam int PROD_W = 2 * FRAC_W;
    localparam int ERR_W  = FRAC_W + 2;

    // Input register.
    logic                 r_in_valid;
    logic [1:0]           r_action;
    logic [TIME_BITS-1:0] r_now;
    logic [FRAC_W-1:0]    r_setpoint;
    logic                 r_tv;
    logic                 r_fault;

    // Sequencer state.
    logic                 r_armed,   n_armed;
    logic [FRAC_W-1:0]    r_applied, n_applied;
    logic [TIME_BITS-1:0] r_last,    n_last;
    logic [TIME_BITS-1:0] r_req,     n_req;
    logic                 r_shut,    n_shut;
    logic                 r_remote,  n_remote;
    logic                 r_enable,  n_enable;

    // Stage register.
    logic                 r_step_valid;
    t_step                r_step;

    logic                 advance;
    logic [TIME_BITS-1:0] dt;
    logic [DT_W-1:0]      dt_ext;
    logic [TIME_BITS-1:0] since;
    logic [FRAC_W-1:0]    rate;
    logic [PROD_W-1:0]    prod;
    logic                 step_sat;
    logic [FRAC_W:0]      step;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] nxt;
    logic [FRAC_W-1:0]    slewed;

    assign advance      = r_in_valid && (!r_step_valid || i_step_ready);
    assign o_in_ready   = !r_in_valid || advance;
    assign o_step_valid = r_step_valid;
    assign o_step       = r_step;

    // Slew step: step = min(rate * dt, 2.0), error limited to +-step, clamp 0..1.
    always_comb begin
        dt       = r_now - r_last;
        since    = r_now - r_req;
        dt_ext   = DT_W'(dt);
        rate     = r_shut ? i_cfg.shutdown_rate : i_cfg.normal_rate;
        prod     = PROD_W'(rate) * PROD_W'(dt_ext[FRAC_W-1:0]);
        step_sat = ((|dt_ext[DT_W-1:FRAC_W]) && (|rate)) || (prod >= PROD_W'(STEP_MAX));
        step     = step_sat ? STEP_MAX : prod[FRAC_W:0];
        err      = $signed({2'b00, r_setpoint}) - $signed({2'b00, r_applied});
        if (err > $signed({1'b0, step})) begin
            err = $signed({1'b0, step});
        end else if (err < -$signed({1'b0, step})) begin
            err = -$signed({1'b0, step});
        end
        nxt = $signed({2'b00, r_applied}) + err;
        if (nxt < 0) begin
            slewed = '0;
        end else if (nxt > $signed({2'b00, ONE_FRAC})) begin
            slewed = ONE_FRAC;
        end else begin
            slewed = nxt[FRAC_W-1:0];
        end
    end

    // Next state for the word in the input register.
    always_comb begin
        n_armed   = r_armed;
        n_applied = r_applied;
        n_last    = r_last;
        n_req     = r_req;
        n_shut    = r_shut;
        n_remote  = r_remote;
        n_enable  = r_enable;
        unique case (r_action)
            ACT_TICK: begin
                n_last    = r_now;
                n_applied = (r_armed && slewed == '0) ? MIN_ARMED : slewed;
                if (r_armed) begin
                    if (i_cfg.via_link) begin
                        n_remote = r_tv && !r_fault;
                        n_enable = r_tv && !r_fault;
                    end else begin
                        n_enable = 1'b1;
                        n_remote = since >= TIME_BITS'(i_cfg.settle_ms);
                    end
                end else if (n_applied <= OFF_THRESH || since > OFF_TIMEOUT_MS) begin
                    n_remote = 1'b0;
                    n_enable = 1'b0;
                end
            end
            ACT_ARM: begin
                if (!r_armed) begin
                    n_armed = 1'b1;
                    n_shut  = 1'b0;
                    n_req   = r_now;
                end
            end
            ACT_DISARM: begin
                if (r_armed) begin
                    n_armed = 1'b0;
                    n_shut  = 1'b1;
                    n_req   = r_now;
                end
            end
            default: begin
            end
        endcase
    end

    // Input register load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_action   <= i_action;
            r_now      <= i_now_ms;
            r_setpoint <= i_setpoint;
            r_tv       <= i_telemetry_valid;
            r_fault    <= i_supply_fault;
        end
    end

    // State update and stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_applied    <= '0;
            r_last       <= '0;
            r_req        <= '0;
            r_shut       <= 1'b0;
            r_remote     <= 1'b0;
            r_enable     <= 1'b0;
            r_step_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_armed   <= n_armed;
                r_applied <= n_applied;
                r_last    <= n_last;
                r_req     <= n_req;
                r_shut    <= n_shut;
                r_remote  <= n_remote;
                r_enable  <= n_enable;
            end
            if (advance) begin
                r_step_valid <= 1'b1;
            end else if (i_step_ready) begin
                r_step_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_step.applied      <= n_applied;
            r_step.remote       <= n_remote;
            r_step.enable       <= n_enable;
            r_step.telemetry_ok <= i_cfg.via_link ? r_tv : n_armed;
            r_step.armed        <= n_armed;
        end
    end

endmodule

### design/sls_level.sv
// Output stage of the supply sequencer: scales the applied fraction into the
// saturated link level and holds the result word. Depends on sls_pkg.
`timescale 1ns / 1ps

module sls_level (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sls_pkg::t_cfg                   i_cfg,
    input  logic                            i_step_valid,
    output logic                            o_step_ready,
    input  sls_pkg::t_step                  i_step,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [sls_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import sls_pkg::*;

    localparam int MUL_W = FRAC_W + SCALE_W;
    localparam int SHR_W = MUL_W - SCALE_SH;
    localparam int PAD_W = OUT_TDATA_W - 2 * FRAC_W - 4;

    logic              r_valid;
    t_step             r_step;
    logic [FRAC_W-1:0] r_level;

    logic [MUL_W-1:0]  prod;
    logic [SHR_W-1:0]  shr;
    logic [FRAC_W-1:0] level;
    logic              take;

    assign o_step_ready = !r_valid || i_m_axis_tready;
    assign take         = i_step_valid && o_step_ready;

    // Level = applied * scale / 2^16, saturated at 1.0; zero in analog mode.
    always_comb begin
        prod = MUL_W'(i_step.applied) * MUL_W'(i_cfg.level_scale);
        shr  = prod[MUL_W-1:SCALE_SH];
        if (!i_cfg.via_link) begin
            level = '0;
        end else if (shr > SHR_W'(ONE_FRAC)) begin
            level = ONE_FRAC;
        end else begin
            level = shr[FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_step_ready) begin
            r_valid <= i_step_valid;
        end
        if (take) begin
            r_step  <= i_step;
            r_level <= level;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {PAD_W'(0), r_step.armed, r_step.telemetry_ok,
                              r_step.enable, r_step.remote, r_level, r_step.applied};

endmodule

### design/slew_limited_supply_sequencer.sv
// Slew limited supply sequencer: after its input word is accepted, a result word
// passes the input register, then the step register, then the output register.
// Throughput is one word per cycle while the output is not stalled; the state loop
// (slew multiply, clamps and sequencing compares) is combinational between the
// input and step registers. Synchronous active-low reset clears the state, the
// configuration to its defaults and all valid flags; no clearing pass is needed.
`timescale 1ns / 1ps

module slew_limited_supply_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sls_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sls_pkg::FRAC_W-1:0]      i_cfg_data,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: now_ms[31:0], setpoint_frac[56:32], telemetry_valid[57],
    //        supply_fault[58], zero[63:59]
    input  logic [sls_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]                      s_axis_tuser,
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: applied_frac[24:0], level_frac[49:25], remote_high[50],
    //        output_enable[51], telemetry_ok[52], armed[53], zero[55:54]
    output logic [sls_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import sls_pkg::*;

    localparam int SP_LO = TIME_BITS;
    localparam int TV_B  = TIME_BITS + FRAC_W;

    t_cfg  cfg;
    t_step step;
    logic  step_valid;
    logic  step_ready;

    sls_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sls_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_in_valid        (s_axis_tvalid),
        .o_in_ready        (s_axis_tready),
        .i_action          (s_axis_tuser),
        .i_now_ms          (s_axis_tdata[TIME_BITS-1:0]),
        .i_setpoint        (s_axis_tdata[SP_LO+FRAC_W-1:SP_LO]),
        .i_telemetry_valid (s_axis_tdata[TV_B]),
        .i_supply_fault    (s_axis_tdata[TV_B+1]),
        .o_step_valid      (step_valid),
        .i_step_ready      (step_ready),
        .o_step            (step)
    );

    sls_level u_level (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_step_valid    (step_valid),
        .o_step_ready    (step_ready),
        .i_step          (step),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata)
    );

endmodule

### dv/tb.sv
// Self-checking testbench for the slew limited supply sequencer: drives timestamped
// arm, disarm and tick words, predicts every result word, and compares field by field.
// Depends on sls_pkg and slew_limited_supply_sequencer from the design folder.
`timescale 1ns / 1ps

module tb;
    import sls_pkg::*;

    // Fixed-point constants of the supply sequencing, 24 fraction bits.
    localparam longint FULL_L = longint'(1) << 24;
    localparam logic [24:0] FULL_FRAC = 25'(FULL_L);
    localparam logic [24:0] MIN_ON_FRAC = 25'((FULL_L + 500) / 1000);
    localparam logic [24:0] OFF_FRAC = 25'(FULL_L / 100);
    localparam logic [31:0] SHUTDOWN_TIMEOUT_MS = 32'd3000;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_WORDS = 93;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic [24:0] setpoint;
        logic        tel_valid;
        logic        fault;
    } t_supply_event;

    typedef struct {
        logic [24:0] applied;
        logic [24:0] level;
        logic        remote;
        logic        enable;
        logic        tel_ok;
        logic        armed;
    } t_supply_result;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_THIRD, RX_SPARSE} t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [FRAC_W-1:0]      i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    slew_limited_supply_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mirror of the configuration registers, at their reset values.
    logic        cfg_via_link = 1'b0;
    logic [24:0] cfg_normal_rate = 25'd1678;
    logic [24:0] cfg_shutdown_rate = 25'd3355;
    logic [15:0] cfg_settle_ms = 16'd50;
    logic [17:0] cfg_level_scale = 18'd65536;

    // Mirror of the sequencer state.
    logic        is_armed = 1'b0;
    logic [24:0] applied_lvl = '0;
    logic [31:0] last_tick_ms = '0;
    logic [31:0] request_ms = '0;
    logic        on_shutdown_rate = 1'b0;
    logic        remote_lvl = 1'b0;
    logic        enable_lvl = 1'b0;

    t_supply_event  event_q[$];
    t_supply_result predicted_q[$];
    int             queued_total = 0;
    int             result_count = 0;
    int             mismatches = 0;
    logic [31:0]    stim_ms = '0;

    // Register write as the block would take it: each register keeps its own width.
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [24:0] value);
        case (idx)
            CFG_VIA_LINK:      cfg_via_link = value[0];
            CFG_NORMAL_RATE:   cfg_normal_rate = value;
            CFG_SHUTDOWN_RATE: cfg_shutdown_rate = value;
            CFG_SETTLE_MS:     cfg_settle_ms = value[15:0];
            CFG_LEVEL_SCALE:   cfg_level_scale = value[17:0];
            default: ;
        endcase
    endfunction

    // Move the fraction toward the target by at most rate * dt, then clamp to 0..1.
    function automatic logic [24:0] slew_toward(logic [24:0] cur, logic [24:0] tgt,
                                                logic [31:0] dt);
        longint rate;
        longint step;
        longint err;
        longint nxt;
        rate = on_shutdown_rate ? longint'(cfg_shutdown_rate) : longint'(cfg_normal_rate);
        step = rate * longint'(dt);
        if (dt == 0) return cur;
        if (step > 2 * FULL_L) step = 2 * FULL_L;
        err = longint'(tgt) - longint'(cur);
        if (err > step) err = step;
        else if (err < -step) err = -step;
        nxt = longint'(cur) + err;
        if (nxt < 0) nxt = 0;
        if (nxt > FULL_L) nxt = FULL_L;
        return 25'(nxt);
    endfunction

    // Advance the mirrored state by one input word and return the result it causes.
    function automatic t_supply_result step_sequencer(t_supply_event ev);
        t_supply_result res;
        logic [31:0] since;
        logic [42:0] scaled;
        if (ev.action == ACT_TICK) begin
            applied_lvl = slew_toward(applied_lvl, ev.setpoint, ev.now_ms - last_tick_ms);
            last_tick_ms = ev.now_ms;
            if (is_armed && applied_lvl == 0) applied_lvl = MIN_ON_FRAC;
            since = ev.now_ms - request_ms;
            if (is_armed) begin
                if (cfg_via_link) begin
                    remote_lvl = ev.tel_valid && !ev.fault;
                    enable_lvl = ev.tel_valid && !ev.fault;
                end else begin
                    enable_lvl = 1'b1;
                    remote_lvl = since >= 32'(cfg_settle_ms);
                end
            end else if (applied_lvl <= OFF_FRAC || since > SHUTDOWN_TIMEOUT_MS) begin
                remote_lvl = 1'b0;
                enable_lvl = 1'b0;
            end
        end else if (ev.action == ACT_ARM) begin
            if (!is_armed) begin
                is_armed = 1'b1;
                on_shutdown_rate = 1'b0;
                request_ms = ev.now_ms;
            end
        end else if (ev.action == ACT_DISARM) begin
            if (is_armed) begin
                is_armed = 1'b0;
                on_shutdown_rate = 1'b1;
                request_ms = ev.now_ms;
            end
        end
        // The link level is the applied fraction scaled by a Q16 ratio, saturated at 1.0.
        res.level = '0;
        if (cfg_via_link) begin
            scaled = applied_lvl * cfg_level_scale;
            scaled = scaled >> 16;
            res.level = (scaled > 43'(FULL_FRAC)) ? FULL_FRAC : scaled[24:0];
        end
        res.applied = applied_lvl;
        res.remote = remote_lvl;
        res.enable = enable_lvl;
        res.tel_ok = cfg_via_link ? ev.tel_valid : is_armed;
        res.armed = is_armed;
        return res;
    endfunction

    function automatic void check_field(string name, logic [24:0] want, logic [24:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                         $time, name, result_count, want, got);
        end
    endfunction

    // Sender side: bursts of random length with random gaps between them.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            predicted_q.push_back(step_sequencer(event_q[0]));
            void'(event_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (event_q.size() != 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {5'b0, event_q[0].fault, event_q[0].tel_valid,
                             event_q[0].setpoint, event_q[0].now_ms};
            s_axis_tuser <= event_q[0].action;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver side: one of four stall patterns, chosen at random and changed when its run ends.
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int unsigned rx_cycle = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 9) < 7);
            RX_THIRD:  m_axis_tready <= (rx_cycle % 3 == 0);
            default:   m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Result checking against the oldest prediction.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (predicted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with no prediction waiting: %h",
                             $time, m_axis_tdata);
            end else begin
                check_field("applied_frac", predicted_q[0].applied, m_axis_tdata[24:0]);
                check_field("level_frac", predicted_q[0].level, m_axis_tdata[49:25]);
                check_field("remote_high", 25'(predicted_q[0].remote),
                            25'(m_axis_tdata[50]));
                check_field("output_enable", 25'(predicted_q[0].enable),
                            25'(m_axis_tdata[51]));
                check_field("telemetry_ok", 25'(predicted_q[0].tel_ok),
                            25'(m_axis_tdata[52]));
                check_field("armed", 25'(predicted_q[0].armed), 25'(m_axis_tdata[53]));
                check_field("padding", 25'd0, 25'(m_axis_tdata[55:54]));
                void'(predicted_q.pop_front());
            end
            result_count++;
        end
    end

    task automatic queue_event(logic [1:0] action, logic [31:0] now_ms, logic [24:0] setpoint,
                               logic tel_valid, logic fault);
        t_supply_event ev;
        ev.action = action;
        ev.now_ms = now_ms;
        ev.setpoint = setpoint;
        ev.tel_valid = tel_valid;
        ev.fault = fault;
        event_q.push_back(ev);
        queued_total++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The sender holds off until every predicted result has come back.
    task automatic drain();
        while (event_q.size() != 0 || predicted_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [24:0] pick_setpoint();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FULL_FRAC;
            2:       return 25'($urandom_range(32'(FULL_FRAC), 32'h1FF_FFFF));
            default: return 25'($urandom_range(0, 32'(FULL_FRAC)));
        endcase
    endfunction

    function automatic logic [31:0] pick_dt();
        case ($urandom_range(0, 29))
            0, 1:    return '0;
            2, 3:    return $urandom_range(200, 4000);
            4:       return $urandom;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // One arm, ramp, disarm and ramp-down sequence, with an occasional stray action.
    task automatic power_cycle();
        logic [24:0] target;
        logic [1:0]  act;
        int          n;
        target = pick_setpoint();
        stim_ms += $urandom_range(0, 30);
        queue_event(ACT_ARM, stim_ms, pick_setpoint(), 1'($urandom), 1'($urandom));
        n = $urandom_range(4, 20);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0) target = pick_setpoint();
            act = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 3)) : ACT_TICK;
            stim_ms += pick_dt();
            queue_event(act, stim_ms, target, $urandom_range(0, 9) != 0,
                        $urandom_range(0, 9) == 0);
        end
        stim_ms += $urandom_range(0, 20);
        queue_event(ACT_DISARM, stim_ms, pick_setpoint(), 1'($urandom), 1'($urandom));
        n = $urandom_range(3, 15);
        repeat (n) begin
            stim_ms += pick_dt();
            queue_event(ACT_TICK, stim_ms, ($urandom_range(0, 2) == 0) ? pick_setpoint() : '0,
                        1'($urandom), 1'($urandom));
        end
    endtask

    // Register settings per phase; phases 1 to 3 hold the extremes.
    task automatic configure_phase(int phase);
        case (phase)
            0: begin
                write_reg(CFG_VIA_LINK, {24'($urandom), 1'b1});
                write_reg(CFG_NORMAL_RATE, 25'($urandom_range(2000, 200000)));
                write_reg(CFG_SHUTDOWN_RATE, 25'($urandom_range(2000, 200000)));
                write_reg(CFG_SETTLE_MS, 25'($urandom_range(0, 100)));
                write_reg(CFG_LEVEL_SCALE, 25'd65536);
            end
            1: begin
                write_reg(CFG_VIA_LINK, {24'($urandom), 1'b0});
                write_reg(CFG_NORMAL_RATE, 25'h1FF_FFFF);
                write_reg(CFG_SHUTDOWN_RATE, '0);
                write_reg(CFG_SETTLE_MS, '0);
                write_reg(CFG_LEVEL_SCALE, '0);
            end
            2: begin
                write_reg(CFG_VIA_LINK, {24'($urandom), 1'b1});
                write_reg(CFG_NORMAL_RATE, '0);
                write_reg(CFG_SHUTDOWN_RATE, FULL_FRAC);
                write_reg(CFG_SETTLE_MS, 25'h1FF_FFFF);
                write_reg(CFG_LEVEL_SCALE, 25'h1FF_FFFF);
                // Unassigned register indexes must leave the settings untouched.
                for (int k = CFG_LEVEL_SCALE + 1; k < 2 ** CFG_IDX_W; k++)
                    write_reg(CFG_IDX_W'(k), 25'($urandom));
            end
            3: begin
                write_reg(CFG_VIA_LINK, {24'($urandom), 1'b0});
                write_reg(CFG_NORMAL_RATE, FULL_FRAC);
                write_reg(CFG_SHUTDOWN_RATE, 25'd1);
                write_reg(CFG_SETTLE_MS, 25'd65535);
                write_reg(CFG_LEVEL_SCALE, 25'd131072);
            end
            default: begin
                write_reg(CFG_VIA_LINK, 25'($urandom));
                write_reg(CFG_NORMAL_RATE, ($urandom_range(0, 3) == 0) ? 25'($urandom)
                                           : 25'($urandom_range(0, 300000)));
                write_reg(CFG_SHUTDOWN_RATE, ($urandom_range(0, 3) == 0) ? 25'($urandom)
                                             : 25'($urandom_range(0, 300000)));
                write_reg(CFG_SETTLE_MS, 25'($urandom_range(0, 200)));
                write_reg(CFG_LEVEL_SCALE, 25'($urandom_range(0, 131072)));
            end
        endcase
    endtask

    // Directed words at reset settings: holds, ignored requests, clamps, timeout, wrap.
    task automatic load_directed();
        queue_event(ACT_TICK, 32'd0, FULL_FRAC, 1'b0, 1'b0);
        queue_event(ACT_SPARE, 32'd1, '0, 1'b1, 1'b0);
        queue_event(ACT_DISARM, 32'd2, '0, 1'b0, 1'b1);
        queue_event(ACT_ARM, 32'd5, '0, 1'b0, 1'b0);
        queue_event(ACT_ARM, 32'd6, '0, 1'b1, 1'b1);
        queue_event(ACT_TICK, 32'd5, '0, 1'b1, 1'b1);
        queue_event(ACT_TICK, 32'd60, FULL_FRAC, 1'b1, 1'b0);
        queue_event(ACT_TICK, 32'd60, FULL_FRAC, 1'b0, 1'b0);
        queue_event(ACT_TICK, 32'd10060, 25'h1FF_FFFF, 1'b1, 1'b0);
        queue_event(ACT_SPARE, 32'd10061, 25'h1FF_FFFF, 1'b1, 1'b1);
        queue_event(ACT_DISARM, 32'd10100, '0, 1'b0, 1'b0);
        queue_event(ACT_DISARM, 32'd10101, '0, 1'b0, 1'b0);
        queue_event(ACT_TICK, 32'd10200, '0, 1'b1, 1'b0);
        queue_event(ACT_TICK, 32'd13101, '0, 1'b0, 1'b1);
        queue_event(ACT_ARM, 32'hFFFF_FFF0, FULL_FRAC, 1'b1, 1'b0);
        queue_event(ACT_TICK, 32'hFFFF_FFFF, FULL_FRAC, 1'b1, 1'b0);
        queue_event(ACT_TICK, 32'h0000_0040, FULL_FRAC, 1'b0, 1'b0);
        queue_event(ACT_TICK, 32'h0000_0040, '0, 1'b1, 1'b1);
        queue_event(ACT_DISARM, 32'h0000_0050, '0, 1'b1, 1'b0);
        queue_event(ACT_TICK, 32'h0001_0050, '0, 1'b0, 1'b0);
        queue_event(ACT_TICK, 32'hFFFF_FFFF, 25'h1FF_FFFF, 1'b1, 1'b1);
        stim_ms = 32'hFFFF_FFFF;
    endtask

    // Stimulus: reset, directed words, then random phases under changing settings.
    initial begin
        int phase_end;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        load_directed();
        drain();
        for (int p = 0; p < PHASES; p++) begin
            configure_phase(p);
            phase_end = queued_total + PHASE_WORDS;
            while (queued_total < phase_end) begin
                case ($urandom_range(0, 9))
                    7, 8: begin
                        repeat (4) begin
                            if ($urandom_range(0, 4) == 0) stim_ms = $urandom;
                            else stim_ms += pick_dt();
                            queue_event(2'($urandom), stim_ms, 25'($urandom),
                                        1'($urandom), 1'($urandom));
                        end
                    end
                    9: begin
                        stim_ms = $urandom;
                        queue_event(ACT_TICK, stim_ms, pick_setpoint(),
                                    1'($urandom), 1'($urandom));
                    end
                    default: power_cycle();
                endcase
            end
            drain();
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
design/sls_pkg.sv
design/sls_cfg.sv
design/sls_core.sv
design/sls_level.sv
design/slew_limited_supply_sequencer.sv
dv/tb.sv
